### hdl/sipq_pkg.sv
`timescale 1ns / 1ps

package sipq_pkg;

  localparam int CAPACITY = 8;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // command queue between acceptance and execution
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [1:0] status_t;

  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_ELEMENT  = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] new_value;
  } sipq_in_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } sipq_out_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } sipq_cmd_t;

  // queue status seen by the acceptance side and the execution side
  typedef struct packed {
    logic full;
    logic empty;
  } sipq_qstat_t;

endpackage

### hdl/sipq_queue.sv
`timescale 1ns / 1ps

module sipq_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sipq_pkg::sipq_cmd_t push_cmd,
  input  logic                pop,
  output sipq_pkg::sipq_cmd_t pop_cmd,
  output sipq_pkg::sipq_qstat_t stat
);
  import sipq_pkg::*;

  sipq_cmd_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/sipq_back.sv
`timescale 1ns / 1ps

module sipq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  sipq_pkg::sipq_cmd_t   cmd,
  output logic                  pop,
  output logic                  out_strobe,
  output sipq_pkg::sipq_out_t   out_data
);
  import sipq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic signed [VAL_W-1:0] store_r   [CAPACITY];
  logic signed [VAL_W-1:0] store_nxt [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  sipq_out_t               out_data_r, out_data_nxt;
  logic [CAPACITY-1:0]     gt;
  logic                    is_full;
  logic                    do_insert;
  logic                    read_last;
  logic [CNT_W-1:0]        count_m1;

  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign do_insert = pop && (cmd.op == OP_INSERT) && !is_full;
  assign count_m1  = count_r - CNT_W'(1);
  assign read_last = (CNT_W'(idx_r) == count_m1);

  // occupied slots holding a value greater than the new one; a thermometer mask
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (store_r[i] > cmd.value);
    end
  end

  // shift the larger entries up by one and drop the new value into the gap
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || CNT_W'(i) == count_r) begin
        store_nxt[i] = cmd.value;
      end else begin
        store_nxt[i] = store_r[i];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (cmd.op == OP_INSERT) begin
            out_strobe_nxt      = 1'b1;
            out_data_nxt.last   = 1'b1;
            out_data_nxt.status = is_full ? ST_FULL : ST_INSERTED;
            if (!is_full) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            out_strobe_nxt      = 1'b1;
            out_data_nxt.last   = 1'b1;
            out_data_nxt.status = ST_EMPTY;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        out_strobe_nxt         = 1'b1;
        out_data_nxt.status    = ST_ELEMENT;
        out_data_nxt.out_value = store_r[idx_r];
        out_data_nxt.last      = read_last;
        if (read_last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (do_insert) begin
      store_r <= store_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

### hdl/sorted_insert_priority_queue.sv
`timescale 1ns / 1ps

// Sorted priority queue of up to CAPACITY signed 32-bit values, kept in
// ascending order; equal values keep arrival order. A request is taken when
// start is high and busy is low; up to two requests wait in a command queue,
// and busy rises only when that queue is full. Each result appears for one
// cycle with out_strobe and cannot be held off. An insert, or a read-out of
// an empty queue, produces one result, registered in the command queue and
// then in the output register; a read-out of N stored values takes the
// engine from S_IDLE into S_READ and then produces N consecutive results,
// popping no further command until the last. The insert is done by
// parallel compare-and-shift over all slots; the read-out rate is set by
// the single read index stepping once per cycle.
module sorted_insert_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sipq_pkg::sipq_in_t  in_data,
  output logic                out_strobe,
  output sipq_pkg::sipq_out_t out_data
);
  import sipq_pkg::*;

  sipq_cmd_t   push_cmd;
  sipq_cmd_t   pop_cmd;
  sipq_qstat_t qstat;
  logic        push;
  logic        pop;

  // classify the request before it enters the queue
  assign busy           = qstat.full;
  assign push           = start && !busy;
  assign push_cmd.op    = in_data.req_type ? OP_READ : OP_INSERT;
  assign push_cmd.value = in_data.req_type ? '0 : in_data.new_value;

  sipq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (qstat)
  );

  sipq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (qstat.empty),
    .cmd        (pop_cmd),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
